/* sv/q2e_pkg.sv */
// ============================================================================
// q2e_pkg
// Shared types and constants for the quaternion to Euler angle converter.
// ============================================================================
package q2e_pkg;

    typedef struct packed {
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
    } t_quat;

    typedef struct packed {
        logic signed [15:0] roll_angle;
        logic signed [15:0] pitch_angle;
        logic signed [15:0] yaw_angle;
    } t_euler;

    localparam int WORK_BITS  = 30;
    localparam int WW         = 48;   // working width of terms and CORDIC vectors
    localparam int ACC_W      = 33;   // angle accumulator, 2^31 per pi
    localparam int ANG_W      = 17;   // rounded angle before wrap / clamp
    localparam int SQRT_STEPS = 31;
    localparam int ROOT_W     = 31;
    localparam int REM_W      = 62;
    localparam int LAT_FIXED  = 38;   // latency minus CORDIC stage count
    localparam int TAB_LEN    = 24;

    localparam logic signed [ACC_W-1:0] ACC_QTR   = 33'sd1073741824;
    localparam logic signed [ANG_W-1:0] PITCH_MAX = 17'sd16384;

    localparam logic signed [ACC_W-1:0] ATAN_TAB [TAB_LEN] = '{
        33'sd536870912, 33'sd316933406, 33'sd167458907, 33'sd85004756,
        33'sd42667331,  33'sd21354465,  33'sd10680862,  33'sd5340245,
        33'sd2670163,   33'sd1335087,   33'sd667544,    33'sd333772,
        33'sd166886,    33'sd83443,     33'sd41722,     33'sd20861,
        33'sd10430,     33'sd5215,      33'sd2608,      33'sd1304,
        33'sd652,       33'sd326,       33'sd163,       33'sd81
    };

endpackage

/* sv/q2e_sqrt.sv */
// ============================================================================
// q2e_sqrt
// Pipelined floor integer square root, one result bit per stage.
// ============================================================================
module q2e_sqrt #(
    parameter int SIDE_W = 33
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [q2e_pkg::REM_W-1:0]  i_rem,
    input  logic [SIDE_W-1:0]          i_side,
    output logic                       o_valid,
    output logic [q2e_pkg::ROOT_W-1:0] o_root,
    output logic [SIDE_W-1:0]          o_side
);
    import q2e_pkg::*;

    logic [REM_W-1:0]      r_n    [SQRT_STEPS];
    logic [REM_W-1:0]      r_res  [SQRT_STEPS];
    logic [SIDE_W-1:0]     r_side [SQRT_STEPS];
    logic [SQRT_STEPS-1:0] r_vld;
    logic [REM_W-1:0]      n_n    [SQRT_STEPS];
    logic [REM_W-1:0]      n_res  [SQRT_STEPS];

    always_comb begin
        logic [REM_W-1:0] a_n;
        logic [REM_W-1:0] a_res;
        logic [REM_W-1:0] t;
        logic [REM_W-1:0] b;
        for (int k = 0; k < SQRT_STEPS; k++) begin
            a_n   = (k == 0) ? i_rem : r_n[(k == 0) ? 0 : k - 1];
            a_res = (k == 0) ? '0 : r_res[(k == 0) ? 0 : k - 1];
            b     = REM_W'(1) << (2 * (SQRT_STEPS - 1 - k));
            t     = a_res + b;
            if (a_n >= t) begin
                n_n[k]   = a_n - t;
                n_res[k] = (a_res >> 1) + b;
            end else begin
                n_n[k]   = a_n;
                n_res[k] = a_res >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < SQRT_STEPS; k++) begin
            r_n[k]    <= n_n[k];
            r_res[k]  <= n_res[k];
            r_side[k] <= (k == 0) ? i_side : r_side[(k == 0) ? 0 : k - 1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[SQRT_STEPS-2:0], i_valid};
        end
    end

    assign o_valid = r_vld[SQRT_STEPS-1];
    assign o_root  = r_res[SQRT_STEPS-1][ROOT_W-1:0];
    assign o_side  = r_side[SQRT_STEPS-1];

endmodule

/* sv/q2e_cordic.sv */
// ============================================================================
// q2e_cordic
// Pipelined vectoring CORDIC atan2, one stage per iteration.
// ============================================================================
module q2e_cordic #(
    parameter int STAGES = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  logic signed [q2e_pkg::WW-1:0]    i_y,
    input  logic signed [q2e_pkg::WW-1:0]    i_x,
    output logic                             o_valid,
    output logic signed [q2e_pkg::ANG_W-1:0] o_angle
);
    import q2e_pkg::*;

    logic signed [WW-1:0]    r_x    [STAGES+1];
    logic signed [WW-1:0]    r_y    [STAGES+1];
    logic signed [ACC_W-1:0] r_acc  [STAGES+1];
    logic                    r_zero [STAGES+1];
    logic [STAGES:0]         r_vld;
    logic signed [ANG_W-1:0] r_ang;
    logic                    r_ovld;

    logic signed [WW-1:0]    n_x;
    logic signed [WW-1:0]    n_y;
    logic signed [ACC_W-1:0] n_acc;
    logic signed [ACC_W-1:0] n_rnd;

    // pre-rotation by +-pi/2 for the left half plane
    always_comb begin
        n_x   = i_x;
        n_y   = i_y;
        n_acc = '0;
        if (i_x < 0) begin
            if (i_y >= 0) begin
                n_x   = i_y;
                n_y   = -i_x;
                n_acc = ACC_QTR;
            end else begin
                n_x   = -i_y;
                n_y   = i_x;
                n_acc = -ACC_QTR;
            end
        end
    end

    assign n_rnd = r_acc[STAGES] + ACC_W'(32768);

    always_ff @(posedge i_clk) begin
        r_x[0]    <= n_x;
        r_y[0]    <= n_y;
        r_acc[0]  <= n_acc;
        r_zero[0] <= (i_x == 0) && (i_y == 0);
        for (int i = 0; i < STAGES; i++) begin
            r_zero[i+1] <= r_zero[i];
            if (r_y[i] >= 0) begin
                r_x[i+1]   <= r_x[i] + (r_y[i] >>> i);
                r_y[i+1]   <= r_y[i] - (r_x[i] >>> i);
                r_acc[i+1] <= r_acc[i] + ATAN_TAB[i];
            end else begin
                r_x[i+1]   <= r_x[i] - (r_y[i] >>> i);
                r_y[i+1]   <= r_y[i] + (r_x[i] >>> i);
                r_acc[i+1] <= r_acc[i] - ATAN_TAB[i];
            end
        end
        r_ang <= r_zero[STAGES] ? '0 : ANG_W'(n_rnd >>> 16);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_ovld <= 1'b0;
        end else begin
            r_vld  <= {r_vld[STAGES-1:0], i_valid};
            r_ovld <= r_vld[STAGES];
        end
    end

    assign o_valid = r_ovld;
    assign o_angle = r_ang;

endmodule

/* sv/quaternion_to_euler_angles.sv */
// ============================================================================
// quaternion_to_euler_angles
// Unit quaternion to ZYX roll, pitch and yaw binary angles.
// ============================================================================
// Usage:
//   A request is taken at a clock edge with start high and busy low. busy is
//   always low, so one quaternion can be issued every cycle.
//   Each result appears on o_euler for exactly one cycle with o_strobe high;
//   the receiver must take it then, there is no backpressure.
//   The datapath registers the products, the terms, the pitch square and
//   1 - s^2, then runs a 31-stage square root for the pitch cosine, a
//   CORDIC_STAGES + 2 deep atan2 pipeline, and an output register.
//   Roll and yaw run their CORDIC in parallel and are delayed to line up.
//   Throughput is one request per cycle, fixed by the fully pipelined datapath.
//   Angles: 32768 = pi; +pi is returned as -32768; pitch within +-16384.
//   Synchronous reset clears all valid bits; requests in flight are dropped.
// ============================================================================
module quaternion_to_euler_angles #(
    parameter int CORDIC_STAGES = 16,
    parameter int FRACTION_BITS = 14
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  q2e_pkg::t_quat   i_quat,
    output logic             o_strobe,
    output q2e_pkg::t_euler  o_euler
);
    import q2e_pkg::*;

    localparam int SH_R     = (2 * FRACTION_BITS >= WORK_BITS) ?
                              2 * FRACTION_BITS - WORK_BITS : 0;
    localparam int SH_L     = (2 * FRACTION_BITS < WORK_BITS) ?
                              WORK_BITS - 2 * FRACTION_BITS : 0;
    localparam int CORDIC_L = CORDIC_STAGES + 2;
    localparam int ROLL_DLY = 2 + SQRT_STEPS;
    localparam logic signed [63:0]   ONE2    = 64'sd1 <<< (2 * FRACTION_BITS);
    localparam logic signed [WW-1:0] ONE_W   = WW'(64'sd1 <<< WORK_BITS);
    localparam logic [REM_W-1:0]     REM_ONE = REM_W'(1) << (2 * WORK_BITS);

    typedef struct packed {
        logic signed [ROOT_W-1:0] sp;
        logic                     sat_p;
        logic                     sat_n;
    } t_pside;

    typedef struct packed {
        logic signed [15:0] roll;
        logic signed [15:0] yaw;
    } t_ry;

    function automatic logic signed [WW-1:0] to_w(input logic signed [63:0] v);
        return WW'((v >>> SH_R) <<< SH_L);
    endfunction

    logic accept;
    logic [3:0] r_vld;

    logic signed [31:0] r_wx, r_yz, r_xx, r_yy, r_wy, r_zx, r_wz, r_xy, r_zz;
    logic signed [WW-1:0] r_sr, r_cr, r_sp, r_sy, r_cy;
    logic signed [ROOT_W-1:0] n_sp31;
    logic signed [REM_W-1:0]  n_sq;
    logic [REM_W-1:0] r_s2, r_rem;
    t_pside r_ps3, r_ps4;

    logic              sq_valid;
    logic [ROOT_W-1:0] sq_root;
    t_pside            sq_side;

    logic                    roll_vld;
    logic signed [ANG_W-1:0] roll_ang, yaw_ang, pitch_ang;
    logic                    pitch_vld;

    t_ry       r_ry [ROLL_DLY];
    logic [1:0] r_fd [CORDIC_L];

    logic signed [15:0] n_pitch;
    t_euler r_out;
    logic   r_strobe;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[2:0], accept};
        end
    end

    // products
    always_ff @(posedge i_clk) begin
        r_wx <= i_quat.quat_w * i_quat.quat_x;
        r_yz <= i_quat.quat_y * i_quat.quat_z;
        r_xx <= i_quat.quat_x * i_quat.quat_x;
        r_yy <= i_quat.quat_y * i_quat.quat_y;
        r_wy <= i_quat.quat_w * i_quat.quat_y;
        r_zx <= i_quat.quat_z * i_quat.quat_x;
        r_wz <= i_quat.quat_w * i_quat.quat_z;
        r_xy <= i_quat.quat_x * i_quat.quat_y;
        r_zz <= i_quat.quat_z * i_quat.quat_z;
    end

    // terms in Q.30
    always_ff @(posedge i_clk) begin
        r_sr <= to_w(64'sd2 * (64'(r_wx) + 64'(r_yz)));
        r_cr <= to_w(ONE2 - 64'sd2 * (64'(r_xx) + 64'(r_yy)));
        r_sp <= to_w(64'sd2 * (64'(r_wy) - 64'(r_zx)));
        r_sy <= to_w(64'sd2 * (64'(r_wz) + 64'(r_xy)));
        r_cy <= to_w(ONE2 - 64'sd2 * (64'(r_yy) + 64'(r_zz)));
    end

    // pitch: saturation and 1 - s^2
    assign n_sp31 = r_sp[ROOT_W-1:0];
    assign n_sq   = n_sp31 * n_sp31;

    always_ff @(posedge i_clk) begin
        r_ps3.sp    <= n_sp31;
        r_ps3.sat_p <= r_sp >= ONE_W;
        r_ps3.sat_n <= r_sp <= -ONE_W;
        r_s2        <= unsigned'(n_sq);
        r_ps4       <= r_ps3;
        r_rem       <= REM_ONE - r_s2;
    end

    q2e_sqrt #(
        .SIDE_W ($bits(t_pside))
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vld[3]),
        .i_rem   (r_rem),
        .i_side  (r_ps4),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    q2e_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_pitch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sq_valid),
        .i_y     (WW'(sq_side.sp)),
        .i_x     (signed'(WW'(sq_root))),
        .o_valid (pitch_vld),
        .o_angle (pitch_ang)
    );

    q2e_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_roll (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vld[1]),
        .i_y     (r_sr),
        .i_x     (r_cr),
        .o_valid (roll_vld),
        .o_angle (roll_ang)
    );

    q2e_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_yaw (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vld[1]),
        .i_y     (r_sy),
        .i_x     (r_cy),
        .o_valid (),
        .o_angle (yaw_ang)
    );

    // align roll/yaw and the pitch saturation flags with the pitch CORDIC
    always_ff @(posedge i_clk) begin
        r_ry[0].roll <= roll_vld ? roll_ang[15:0] : roll_ang[15:0];
        r_ry[0].yaw  <= yaw_ang[15:0];
        for (int k = 1; k < ROLL_DLY; k++) begin
            r_ry[k] <= r_ry[k-1];
        end
        r_fd[0] <= {sq_side.sat_p, sq_side.sat_n};
        for (int k = 1; k < CORDIC_L; k++) begin
            r_fd[k] <= r_fd[k-1];
        end
    end

    always_comb begin
        if (r_fd[CORDIC_L-1][1]) begin
            n_pitch = 16'(PITCH_MAX);
        end else if (r_fd[CORDIC_L-1][0]) begin
            n_pitch = 16'(-PITCH_MAX);
        end else if (pitch_ang > PITCH_MAX) begin
            n_pitch = 16'(PITCH_MAX);
        end else if (pitch_ang < -PITCH_MAX) begin
            n_pitch = 16'(-PITCH_MAX);
        end else begin
            n_pitch = pitch_ang[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_out.roll_angle  <= r_ry[ROLL_DLY-1].roll;
        r_out.pitch_angle <= n_pitch;
        r_out.yaw_angle   <= r_ry[ROLL_DLY-1].yaw;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= pitch_vld;
        end
    end

    assign o_strobe = r_strobe;
    assign o_euler  = r_out;

endmodule

/* sv/q2e_checker.sv */
// ============================================================================
// q2e_checker
// Port-level checks for the quaternion to Euler angle converter.
// ============================================================================
module q2e_checker #(
    parameter int CORDIC_STAGES = 16
) (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            start,
    input logic            busy,
    input q2e_pkg::t_quat  i_quat,
    input logic            o_strobe,
    input q2e_pkg::t_euler o_euler
);
    import q2e_pkg::*;

    localparam int LAT = CORDIC_STAGES + LAT_FIXED;

    a_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, LAT))
        else $error("result without matching request");

    a_pitch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_euler.pitch_angle >= -16'sd16384) &&
                     (o_euler.pitch_angle <= 16'sd16384))
        else $error("pitch out of range");

    a_zero_quat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && $past(start && !busy && (i_quat == '0), LAT))
        |-> (o_euler == '0))
        else $error("zero quaternion gave nonzero angles");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe)
        else $error("strobe right after reset");

endmodule

bind quaternion_to_euler_angles q2e_checker #(
    .CORDIC_STAGES (CORDIC_STAGES)
) u_q2e_checker (.*);

/* verif/tb_top.sv */
// ============================================================================
// tb_top
// Self-checking bench for the quaternion to Euler angle converter: drives
// directed and random quaternions, predicts roll, pitch and yaw with a
// bit-exact CORDIC model and compares every strobed result in order.
// ============================================================================
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import q2e_pkg::*;

    localparam int STAGES = 16;
    localparam int FRAC   = 14;
    localparam int LAT    = STAGES + LAT_FIXED;

    class euler_scoreboard;
        t_euler pending[$];
        int     mismatches;

        static function longint shr_fl(longint v, int s);
            return v >>> s;
        endfunction

        static function longint work_term(longint v);
            if (2 * FRAC >= WORK_BITS) return shr_fl(v, 2 * FRAC - WORK_BITS);
            return v * (longint'(1) << (WORK_BITS - 2 * FRAC));
        endfunction

        static function longint int_sqrt(longint n);
            longint res, b;
            res = 0;
            b = longint'(1) << 62;
            while (b > n) b = b >> 2;
            while (b != 0) begin
                if (n >= res + b) begin
                    n = n - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
            return res;
        endfunction

        static function longint atan2_bam(longint y, longint x);
            longint acc, t, dx, dy;
            acc = 0;
            if (x == 0 && y == 0) return 0;
            if (x < 0) begin
                t = x;
                if (y >= 0) begin
                    x = y; y = -t; acc = longint'(1) << 30;
                end else begin
                    x = -y; y = t; acc = -(longint'(1) << 30);
                end
            end
            for (int i = 0; i < STAGES && i < TAB_LEN; i++) begin
                dx = shr_fl(y, i);
                dy = shr_fl(x, i);
                if (y >= 0) begin
                    x += dx; y -= dy; acc += longint'(ATAN_TAB[i]);
                end else begin
                    x -= dx; y += dy; acc -= longint'(ATAN_TAB[i]);
                end
            end
            return shr_fl(acc + 32768, 16);
        endfunction

        function void note_request(t_quat q);
            longint w, x, y, z, one2, onew, sr, cr, sp, sy, cy, p;
            t_euler e;
            w = q.quat_w; x = q.quat_x; y = q.quat_y; z = q.quat_z;
            one2 = longint'(1) << (2 * FRAC);
            onew = longint'(1) << WORK_BITS;
            sr = work_term(2 * (w * x + y * z));
            cr = work_term(one2 - 2 * (x * x + y * y));
            sp = work_term(2 * (w * y - z * x));
            sy = work_term(2 * (w * z + x * y));
            cy = work_term(one2 - 2 * (y * y + z * z));
            if (sp >= onew) p = 16384;
            else if (sp <= -onew) p = -16384;
            else begin
                p = atan2_bam(sp, int_sqrt((longint'(1) << 60) - sp * sp));
                if (p > 16384) p = 16384;
                if (p < -16384) p = -16384;
            end
            e.roll_angle  = 16'(atan2_bam(sr, cr));
            e.pitch_angle = 16'(p);
            e.yaw_angle   = 16'(atan2_bam(sy, cy));
            pending.push_back(e);
        endfunction

        function void check_result(t_euler got);
            t_euler exp_e;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
                return;
            end
            exp_e = pending.pop_front();
            if (got !== exp_e) begin
                mismatches++;
                if (mismatches <= 10) $display("mismatch: exp %p got %p", exp_e, got);
            end
        endfunction
    endclass

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   start = 1'b0;
    logic   busy;
    t_quat  i_quat = '0;
    logic   o_strobe;
    t_euler o_euler;
    int     gap_pct = 12;
    euler_scoreboard sb = new();

    always #4 i_clk = ~i_clk;

    quaternion_to_euler_angles #(.CORDIC_STAGES(STAGES), .FRACTION_BITS(FRAC)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_quat(i_quat), .o_strobe(o_strobe), .o_euler(o_euler)
    );

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) sb.check_result(o_euler);
    end

    task automatic send_quat(t_quat q);
        while ($urandom_range(99) < gap_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start  <= 1'b1;
        i_quat <= q;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_request(q);
    endtask

    function automatic logic signed [15:0] rnd_comp();
        case ($urandom_range(9))
            0:       return 16'($urandom);
            1:       return $urandom_range(1) ? 16'sd16384 : -16'sd16384;
            2:       return 16'($signed($urandom_range(8)) - 4);
            default: return 16'($signed($urandom_range(32768)) - 16384);
        endcase
    endfunction

    function automatic t_quat unit_quat();
        real a, b, c, d, n;
        t_quat q;
        a = $signed($urandom_range(2000)) - 1000.0;
        b = $signed($urandom_range(2000)) - 1000.0;
        c = $signed($urandom_range(2000)) - 1000.0;
        d = $signed($urandom_range(2000)) - 1000.0;
        n = $sqrt(a * a + b * b + c * c + d * d);
        if (n == 0.0) return '{16'sd16384, 16'sd0, 16'sd0, 16'sd0};
        q.quat_w = 16'($rtoi(a / n * 16384.0));
        q.quat_x = 16'($rtoi(b / n * 16384.0));
        q.quat_y = 16'($rtoi(c / n * 16384.0));
        q.quat_z = 16'($rtoi(d / n * 16384.0));
        return q;
    endfunction

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        t_quat q;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // identity, axis flips, gimbal lock, atan2 origin, +pi wrap, extremes
        send_quat('{16'sd16384, 16'sd0, 16'sd0, 16'sd0});
        send_quat('{-16'sd16384, 16'sd0, 16'sd0, 16'sd0});
        send_quat('{16'sd0, 16'sd16384, 16'sd0, 16'sd0});
        send_quat('{16'sd0, 16'sd0, 16'sd16384, 16'sd0});
        send_quat('{16'sd0, 16'sd0, 16'sd0, 16'sd16384});
        send_quat('{16'sd11585, 16'sd0, 16'sd11585, 16'sd0});
        send_quat('{16'sd11585, 16'sd0, -16'sd11585, 16'sd0});
        send_quat('{16'sd11585, 16'sd11585, 16'sd0, 16'sd0});
        send_quat('{16'sd11585, -16'sd11585, 16'sd0, 16'sd0});
        send_quat('{16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192});
        send_quat('{16'sd8192, -16'sd8192, 16'sd8192, -16'sd8192});
        send_quat('{16'sd0, 16'sd0, 16'sd0, 16'sd0});
        send_quat('{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767});
        send_quat('{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768});
        send_quat('{16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768});
        send_quat('{-16'sd1, 16'sd1, -16'sd1, 16'sd1});
        send_quat('{16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384});
        send_quat('{16'sd5, 16'sd0, 16'sd16384, 16'sd0});
        drain();
        repeat (LAT + 4) @(posedge i_clk);
        for (int phase = 0; phase < 3; phase++) begin
            gap_pct = (phase == 0) ? 12 : (phase == 1) ? 83 : 0;
            for (int n = 0; n < 580; n++) begin
                if ($urandom_range(99) < 80) q = unit_quat();
                else q = '{rnd_comp(), rnd_comp(), rnd_comp(), rnd_comp()};
                send_quat(q);
                if (phase == 0 && n == 300) drain();
            end
        end
        drain();
        repeat (LAT + 10) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("tb: failure");
        $finish;
    end
endmodule

/* files.f */
sv/q2e_pkg.sv
sv/q2e_sqrt.sv
sv/q2e_cordic.sv
sv/quaternion_to_euler_angles.sv
sv/q2e_checker.sv
verif/tb_top.sv
